/* rtl/dcmr_pkg.sv */
// Shared types and constants for the duty-cycled MAC receive controller.
// Holds the transaction payload structs, the configuration struct, the codes and the reset values.
// No dependencies.
`default_nettype none

package dcmr_pkg;

    // Link addresses are compared on their low ADDR_BITS bits only.
    localparam int ADDR_BITS = 64;
    localparam logic [63:0] ADDR_MASK =
        (ADDR_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_BITS) - 64'd1);

    // Event codes carried in the op field.
    localparam logic [2:0] OP_START     = 3'd0;
    localparam logic [2:0] OP_STOP      = 3'd1;
    localparam logic [2:0] OP_FRAME     = 3'd2;
    localparam logic [2:0] OP_BATCH_END = 3'd3;
    localparam logic [2:0] OP_ACK_RES   = 3'd4;
    localparam logic [2:0] OP_TICK      = 3'd5;

    // Frame type codes.
    localparam logic [2:0] FT_REQUEST      = 3'd0;
    localparam logic [2:0] FT_ACK          = 3'd1;
    localparam logic [2:0] FT_DATA         = 3'd2;
    localparam logic [2:0] FT_DATA_PENDING = 3'd3;
    localparam logic [2:0] FT_BROADCAST    = 3'd4;
    localparam logic [2:0] FT_OTHER        = 3'd5;

    // Receive status codes reported in rx_status.
    localparam logic [2:0] RX_STOPPED       = 3'd0;
    localparam logic [2:0] RX_WAIT_REQ      = 3'd1;
    localparam logic [2:0] RX_WAIT_ACK_SENT = 3'd2;
    localparam logic [2:0] RX_WAIT_DATA     = 3'd3;
    localparam logic [2:0] RX_SUCCESS       = 3'd4;
    localparam logic [2:0] RX_FAILED        = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OWN_ADDR        = 2'd0;
    localparam logic [1:0] CFG_DATA_WAIT_TICKS = 2'd1;
    localparam logic [1:0] CFG_WAKE_INTERVAL   = 2'd2;

    localparam logic [63:0] OWN_ADDR_RESET        = 64'd0;
    localparam logic [19:0] DATA_WAIT_TICKS_RESET = 20'd10000;
    localparam logic [31:0] WAKE_INTERVAL_RESET   = 32'd200000;

    typedef struct packed {
        logic [63:0] own_addr;
        logic [19:0] data_wait_ticks;
        logic [31:0] wake_interval;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  frame_type;
        logic        parse_ok;
        logic [63:0] frame_src;
        logic [63:0] frame_dst;
        logic        radio_receiving;
        logic        rx_started;
        logic        tx_ok;
        logic [31:0] cur_phase;
        logic [31:0] wake_phase;
    } t_in_item;

    typedef struct packed {
        logic        deliver;
        logic        drop;
        logic        quit_rx;
        logic        quit_tx;
        logic        send_ack;
        logic [63:0] ack_dst;
        logic [31:0] ack_phase;
        logic [2:0]  rx_status;
        logic [7:0]  fail_count;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/dcmr_fsm.sv */
// Receive handshake state machine: holds the receive state and computes one result per event.
// Depends on dcmr_pkg for the payload structs, configuration struct and codes.
`default_nettype none

module dcmr_fsm (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dcmr_pkg::t_cfg     i_cfg,
    input  wire logic               i_take,
    input  wire dcmr_pkg::t_in_item i_item,
    output dcmr_pkg::t_out_item     o_result
);

    typedef enum logic [2:0] {
        S_STOPPED       = dcmr_pkg::RX_STOPPED,
        S_WAIT_REQ      = dcmr_pkg::RX_WAIT_REQ,
        S_WAIT_ACK_SENT = dcmr_pkg::RX_WAIT_ACK_SENT,
        S_WAIT_DATA     = dcmr_pkg::RX_WAIT_DATA,
        S_SUCCESS       = dcmr_pkg::RX_SUCCESS,
        S_FAILED        = dcmr_pkg::RX_FAILED
    } t_rx_state;

    t_rx_state   r_state, n_state;
    logic [63:0] r_peer, n_peer;
    logic [19:0] r_wait_left, n_wait_left;
    logic        r_wait_armed, n_wait_armed;
    logic [7:0]  r_failures, n_failures;

    logic [63:0] src_masked;
    logic        own_hit;
    logic        peer_hit;
    logic [7:0]  fail_bumped;
    logic [31:0] phase_ofs;
    logic        req_take;
    dcmr_pkg::t_out_item res;

    assign src_masked  = i_item.frame_src & dcmr_pkg::ADDR_MASK;
    assign own_hit     = (i_item.frame_dst & dcmr_pkg::ADDR_MASK)
                         == (i_cfg.own_addr & dcmr_pkg::ADDR_MASK);
    assign peer_hit    = src_masked == (r_peer & dcmr_pkg::ADDR_MASK);
    assign fail_bumped = (r_failures == 8'hFF) ? r_failures : r_failures + 8'd1;

    // The offset wraps through the wake interval when the wake-up phase is not behind.
    assign phase_ofs = (i_item.cur_phase > i_item.wake_phase)
                       ? i_item.cur_phase - i_item.wake_phase
                       : i_item.cur_phase + i_cfg.wake_interval - i_item.wake_phase;

    always_comb begin
        n_state      = r_state;
        n_peer       = r_peer;
        n_wait_left  = r_wait_left;
        n_wait_armed = r_wait_armed;
        n_failures   = r_failures;
        res          = '0;
        req_take     = 1'b0;

        case (i_item.op)
            dcmr_pkg::OP_START: begin
                n_state      = S_WAIT_REQ;
                n_wait_armed = 1'b0;
                n_wait_left  = '0;
            end
            dcmr_pkg::OP_STOP: begin
                n_state      = S_STOPPED;
                n_wait_armed = 1'b0;
                n_wait_left  = '0;
            end
            dcmr_pkg::OP_FRAME: begin
                if (!i_item.parse_ok) begin
                    res.drop = 1'b1;
                end else if (r_state == S_WAIT_REQ) begin
                    if (i_item.frame_type == dcmr_pkg::FT_BROADCAST) begin
                        res.deliver = 1'b1;
                        res.quit_rx = 1'b1;
                        res.quit_tx = 1'b1;
                        n_state     = S_SUCCESS;
                    end else if (i_item.frame_type != dcmr_pkg::FT_REQUEST) begin
                        res.drop = 1'b1;
                    end else if (!own_hit) begin
                        res.drop    = 1'b1;
                        res.quit_tx = 1'b1;
                    end else begin
                        req_take = 1'b1;
                    end
                end else if (r_state == S_WAIT_DATA) begin
                    if (i_item.frame_type == dcmr_pkg::FT_BROADCAST) begin
                        res.deliver = 1'b1;
                        res.quit_rx = 1'b1;
                    end else if (!peer_hit || !own_hit) begin
                        res.drop     = 1'b1;
                        n_wait_left  = i_cfg.data_wait_ticks;
                        n_wait_armed = 1'b1;
                    end else if (i_item.frame_type == dcmr_pkg::FT_REQUEST) begin
                        n_wait_armed = 1'b0;
                        n_wait_left  = '0;
                        req_take     = 1'b1;
                    end else if (i_item.frame_type inside {dcmr_pkg::FT_DATA,
                                                           dcmr_pkg::FT_DATA_PENDING}) begin
                        res.deliver  = 1'b1;
                        n_wait_armed = 1'b0;
                        n_wait_left  = '0;
                        n_state      = S_SUCCESS;
                    end else begin
                        res.drop = 1'b1;
                    end
                end else begin
                    res.drop = 1'b1;
                end
            end
            dcmr_pkg::OP_BATCH_END: begin
                if (r_state == S_WAIT_REQ) begin
                    n_failures = fail_bumped;
                    n_state    = S_FAILED;
                end
            end
            dcmr_pkg::OP_ACK_RES: begin
                if (r_state == S_WAIT_ACK_SENT) begin
                    if (i_item.tx_ok) begin
                        n_wait_left  = i_cfg.data_wait_ticks;
                        n_wait_armed = 1'b1;
                        n_state      = S_WAIT_DATA;
                    end else begin
                        res.quit_rx = 1'b1;
                        n_state     = S_FAILED;
                    end
                end
            end
            dcmr_pkg::OP_TICK: begin
                if (r_state == S_WAIT_DATA && r_wait_armed) begin
                    if (r_wait_left > 20'd1) begin
                        n_wait_left = r_wait_left - 20'd1;
                    end else if (i_item.rx_started) begin
                        n_wait_left  = i_cfg.data_wait_ticks;
                        n_wait_armed = 1'b1;
                    end else begin
                        n_wait_armed = 1'b0;
                        n_wait_left  = '0;
                        n_failures   = fail_bumped;
                        n_state      = S_FAILED;
                    end
                end
            end
            default: begin
            end
        endcase

        // A request for this node: remember the sender and acknowledge unless the radio is busy.
        if (req_take) begin
            n_peer   = src_masked;
            res.drop = 1'b1;
            if (i_item.radio_receiving) begin
                n_failures = fail_bumped;
                n_state    = S_FAILED;
            end else begin
                res.send_ack  = 1'b1;
                res.ack_dst   = src_masked;
                res.ack_phase = phase_ofs;
                n_state       = S_WAIT_ACK_SENT;
            end
        end

        res.rx_status  = n_state;
        res.fail_count = n_failures;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_STOPPED;
            r_peer       <= '0;
            r_wait_left  <= '0;
            r_wait_armed <= 1'b0;
            r_failures   <= '0;
        end else if (i_take) begin
            r_state      <= n_state;
            r_peer       <= n_peer;
            r_wait_left  <= n_wait_left;
            r_wait_armed <= n_wait_armed;
            r_failures   <= n_failures;
        end
    end

endmodule

`default_nettype wire

/* rtl/duty_cycled_mac_receive_fsm.sv */
// Duty-cycled MAC receive controller; depends on dcmr_pkg and dcmr_fsm.
// Results are registered: a result is loaded at the edge that accepts its transaction.
// One transaction per cycle unless stalled; the receive state is updated on acceptance.
// A result register plus a skid register keep the input accepting while one result waits;
// the input stalls only while the skid register is full.
// Reset (i_rst_n low, synchronous) empties the output stage and restores state and config.
`default_nettype none

module duty_cycled_mac_receive_fsm (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Configuration write port.
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_addr,
    input  wire logic [63:0]         i_cfg_wdata,
    // Event input channel.
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire dcmr_pkg::t_in_item  i_in_data,
    // Result output channel.
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output dcmr_pkg::t_out_item      o_out_data
);

    dcmr_pkg::t_cfg      r_cfg;
    dcmr_pkg::t_out_item step_result;
    dcmr_pkg::t_out_item r_out, r_skid;
    logic                r_out_valid, r_skid_valid;
    logic                in_take;
    logic                out_free;

    // An input transaction is taken whenever the skid register is empty.
    assign in_take    = i_in_valid && !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    // The result register can load when it is empty or its transaction completes now.
    assign out_free = !r_out_valid || !i_out_stall;

    // Configuration registers. Writes to an index past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_addr        <= dcmr_pkg::OWN_ADDR_RESET;
            r_cfg.data_wait_ticks <= dcmr_pkg::DATA_WAIT_TICKS_RESET;
            r_cfg.wake_interval   <= dcmr_pkg::WAKE_INTERVAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dcmr_pkg::CFG_OWN_ADDR:        r_cfg.own_addr        <= i_cfg_wdata;
                dcmr_pkg::CFG_DATA_WAIT_TICKS: r_cfg.data_wait_ticks <= i_cfg_wdata[19:0];
                dcmr_pkg::CFG_WAKE_INTERVAL:   r_cfg.wake_interval   <= i_cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    // The state machine advances on every accepted transaction and returns its result
    // combinationally; the result is captured below.
    dcmr_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_take   (in_take),
        .i_item   (i_in_data),
        .o_result (step_result)
    );

    // Output stage. Results leave in order: the skid entry, when present, always holds the
    // result that follows the one in the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_take;
            r_skid_valid <= 1'b0;
        end else if (in_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_take) begin
                r_out <= step_result;
            end
        end else if (in_take) begin
            r_skid <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* rtl/dcmr_checker.sv */
// Port-level checks for the duty-cycled MAC receive controller, bound to the top level.
// Depends on dcmr_pkg and duty_cycled_mac_receive_fsm.
`default_nettype none

module dcmr_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire dcmr_pkg::t_out_item o_out_data
);

    // A stalled result transaction stays presented unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // The input side only stalls when the result register is occupied.
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output stage");

    // A frame is never both delivered and dropped.
    a_deliver_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.deliver && o_out_data.drop))
        else $error("frame both delivered and dropped");

    // An acknowledge consumes the request and leaves the block waiting for the send result.
    a_ack_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.send_ack |->
            o_out_data.drop && o_out_data.rx_status == dcmr_pkg::RX_WAIT_ACK_SENT)
        else $error("acknowledge with wrong status");

    // Without an acknowledge the acknowledge fields read as zero.
    a_ack_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.send_ack |->
            o_out_data.ack_dst == 64'd0 && o_out_data.ack_phase == 32'd0)
        else $error("acknowledge fields set without acknowledge");

endmodule

bind duty_cycled_mac_receive_fsm dcmr_checker u_dcmr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

/* bench/mac_rx_checker.sv */
// Result checker for the duty-cycled MAC receive controller.
// Watches the configuration port and both transaction channels, predicts each result
// and compares it field by field. Depends on dcmr_pkg.
`timescale 1ns / 100ps

module mac_rx_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_addr,
    input  wire logic [63:0]         i_cfg_wdata,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire dcmr_pkg::t_in_item  i_in_data,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire dcmr_pkg::t_out_item i_out_data,
    output int                       o_mismatches,
    output int                       o_pending
);

    // Shadow copy of the configuration and of the receive state.
    dcmr_pkg::t_cfg  cfg;
    logic [2:0]      rx_state;
    logic [63:0]     peer;
    logic [19:0]     ticks_left;
    logic            timer_on;
    logic [7:0]      fail_cnt;

    dcmr_pkg::t_out_item pending_rx_results[$];
    dcmr_pkg::t_out_item want;
    int                  mismatch_count = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic void note_failure();
        if (fail_cnt != 8'hFF) begin
            fail_cnt = fail_cnt + 8'd1;
        end
    endfunction

    function automatic void rearm_timer();
        ticks_left = cfg.data_wait_ticks;
        timer_on   = 1'b1;
    endfunction

    function automatic void stop_timer();
        ticks_left = '0;
        timer_on   = 1'b0;
    endfunction

    // A request for this node: remember the sender, then acknowledge unless the radio is busy.
    function automatic void take_request(input dcmr_pkg::t_in_item ev,
                                         inout dcmr_pkg::t_out_item res);
        logic [31:0] offset;
        peer     = ev.frame_src & dcmr_pkg::ADDR_MASK;
        res.drop = 1'b1;
        if (ev.radio_receiving) begin
            note_failure();
            rx_state = dcmr_pkg::RX_FAILED;
        end else begin
            if (ev.cur_phase > ev.wake_phase) begin
                offset = ev.cur_phase - ev.wake_phase;
            end else begin
                offset = ev.cur_phase + cfg.wake_interval - ev.wake_phase;
            end
            res.send_ack  = 1'b1;
            res.ack_dst   = peer;
            res.ack_phase = offset;
            rx_state      = dcmr_pkg::RX_WAIT_ACK_SENT;
        end
    endfunction

    function automatic dcmr_pkg::t_out_item predict_rx_event(input dcmr_pkg::t_in_item ev);
        dcmr_pkg::t_out_item res;
        logic                to_me;
        logic                from_peer;
        res       = '0;
        to_me     = (ev.frame_dst & dcmr_pkg::ADDR_MASK) == (cfg.own_addr & dcmr_pkg::ADDR_MASK);
        from_peer = (ev.frame_src & dcmr_pkg::ADDR_MASK) == (peer & dcmr_pkg::ADDR_MASK);
        case (ev.op)
            dcmr_pkg::OP_START: begin
                rx_state = dcmr_pkg::RX_WAIT_REQ;
                stop_timer();
            end
            dcmr_pkg::OP_STOP: begin
                rx_state = dcmr_pkg::RX_STOPPED;
                stop_timer();
            end
            dcmr_pkg::OP_FRAME: begin
                if (!ev.parse_ok) begin
                    res.drop = 1'b1;
                end else if (rx_state == dcmr_pkg::RX_WAIT_REQ) begin
                    if (ev.frame_type == dcmr_pkg::FT_BROADCAST) begin
                        res.deliver = 1'b1;
                        res.quit_rx = 1'b1;
                        res.quit_tx = 1'b1;
                        rx_state    = dcmr_pkg::RX_SUCCESS;
                    end else if (ev.frame_type != dcmr_pkg::FT_REQUEST) begin
                        res.drop = 1'b1;
                    end else if (!to_me) begin
                        res.drop    = 1'b1;
                        res.quit_tx = 1'b1;
                    end else begin
                        take_request(ev, res);
                    end
                end else if (rx_state == dcmr_pkg::RX_WAIT_DATA) begin
                    if (ev.frame_type == dcmr_pkg::FT_BROADCAST) begin
                        res.deliver = 1'b1;
                        res.quit_rx = 1'b1;
                    end else if (!from_peer || !to_me) begin
                        res.drop = 1'b1;
                        rearm_timer();
                    end else if (ev.frame_type == dcmr_pkg::FT_REQUEST) begin
                        stop_timer();
                        take_request(ev, res);
                    end else if (ev.frame_type inside {dcmr_pkg::FT_DATA,
                                                       dcmr_pkg::FT_DATA_PENDING}) begin
                        res.deliver = 1'b1;
                        stop_timer();
                        rx_state = dcmr_pkg::RX_SUCCESS;
                    end else begin
                        res.drop = 1'b1;
                    end
                end else begin
                    res.drop = 1'b1;
                end
            end
            dcmr_pkg::OP_BATCH_END: begin
                if (rx_state == dcmr_pkg::RX_WAIT_REQ) begin
                    note_failure();
                    rx_state = dcmr_pkg::RX_FAILED;
                end
            end
            dcmr_pkg::OP_ACK_RES: begin
                if (rx_state == dcmr_pkg::RX_WAIT_ACK_SENT) begin
                    if (ev.tx_ok) begin
                        rearm_timer();
                        rx_state = dcmr_pkg::RX_WAIT_DATA;
                    end else begin
                        res.quit_rx = 1'b1;
                        rx_state    = dcmr_pkg::RX_FAILED;
                    end
                end
            end
            dcmr_pkg::OP_TICK: begin
                if (rx_state == dcmr_pkg::RX_WAIT_DATA && timer_on) begin
                    if (ticks_left > 20'd1) begin
                        ticks_left = ticks_left - 20'd1;
                    end else if (ev.rx_started) begin
                        rearm_timer();
                    end else begin
                        stop_timer();
                        note_failure();
                        rx_state = dcmr_pkg::RX_FAILED;
                    end
                end
            end
            default: begin
            end
        endcase
        res.rx_status  = rx_state;
        res.fail_count = fail_cnt;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, got_val);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.own_addr        = dcmr_pkg::OWN_ADDR_RESET;
            cfg.data_wait_ticks = dcmr_pkg::DATA_WAIT_TICKS_RESET;
            cfg.wake_interval   = dcmr_pkg::WAKE_INTERVAL_RESET;
            rx_state            = dcmr_pkg::RX_STOPPED;
            peer                = '0;
            ticks_left          = '0;
            timer_on            = 1'b0;
            fail_cnt            = '0;
            pending_rx_results.delete();
        end else begin
            // Results are compared before this edge's event is predicted, so a result
            // can never be matched against an event accepted on the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (pending_rx_results.size() == 0) begin
                    $error("result transaction with nothing expected, rx_status 0x%0h",
                           i_out_data.rx_status);
                    mismatch_count++;
                end else begin
                    want = pending_rx_results.pop_front();
                    check_field("deliver", 64'(want.deliver), 64'(i_out_data.deliver));
                    check_field("drop", 64'(want.drop), 64'(i_out_data.drop));
                    check_field("quit_rx", 64'(want.quit_rx), 64'(i_out_data.quit_rx));
                    check_field("quit_tx", 64'(want.quit_tx), 64'(i_out_data.quit_tx));
                    check_field("send_ack", 64'(want.send_ack), 64'(i_out_data.send_ack));
                    check_field("ack_dst", want.ack_dst, i_out_data.ack_dst);
                    check_field("ack_phase", 64'(want.ack_phase),
                                64'(i_out_data.ack_phase));
                    check_field("rx_status", 64'(want.rx_status),
                                64'(i_out_data.rx_status));
                    check_field("fail_count", 64'(want.fail_count),
                                64'(i_out_data.fail_count));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_rx_results.push_back(predict_rx_event(i_in_data));
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    dcmr_pkg::CFG_OWN_ADDR:        cfg.own_addr        = i_cfg_wdata;
                    dcmr_pkg::CFG_DATA_WAIT_TICKS: cfg.data_wait_ticks = i_cfg_wdata[19:0];
                    dcmr_pkg::CFG_WAKE_INTERVAL:   cfg.wake_interval   = i_cfg_wdata[31:0];
                    default: begin
                    end
                endcase
            end
        end
        o_pending    = pending_rx_results.size();
        o_mismatches = mismatch_count;
    end

endmodule

/* bench/testbench.sv */
// Top of the bench for duty_cycled_mac_receive_fsm: clock, reset, register writes and
// event stimulus with random idling; the verdict comes from mac_rx_checker.
// Depends on dcmr_pkg, the block and mac_rx_checker.
`timescale 1ns / 100ps

module testbench;

    // Op and frame type codes the block does not define; they must be ignored or dropped.
    localparam logic [2:0] OP_UNDEF_LO = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;
    localparam logic [2:0] FT_UNDEF_HI = 3'd7;

    localparam logic [63:0] OWN_DIRECTED  = 64'hC3A5_0F1E_7D2B_9648;
    localparam logic [63:0] PEER_DIRECTED = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          HOLD_CYCLES   = 60;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_addr;
    logic [63:0]         cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    dcmr_pkg::t_in_item  in_data;
    logic                out_valid;
    logic                out_stall;
    dcmr_pkg::t_out_item out_data;

    int          mismatches;
    int          pending;

    // Stimulus bookkeeping only; the checker owns the prediction.
    logic        in_accepted = 1'b0;
    logic [63:0] own_now = '0;
    int          sent_items = 0;
    int          send_idle_pct = 21;
    int          recv_idle_pct = 87;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;

    duty_cycled_mac_receive_fsm u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    mac_rx_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Acceptance is registered at the rising edge so the sender, which works on the
    // falling edge, reads a settled value.
    always @(posedge clk) begin
        in_accepted <= in_valid && !in_stall;
    end

    // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
    // During a hold-off the output stage fills and the block has to stall its input.
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Hard limit on the run, far beyond the slowest passing run.
    initial begin
        #4_800_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [63:0] rand_addr();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Every field gets random content; the caller overrides the ones that matter.
    function automatic dcmr_pkg::t_in_item rand_event(input logic [2:0] op);
        dcmr_pkg::t_in_item ev;
        ev.op              = op;
        ev.frame_type      = 3'($urandom_range(0, 7));
        ev.parse_ok        = 1'($urandom_range(0, 1));
        ev.frame_src       = rand_addr();
        ev.frame_dst       = rand_addr();
        ev.radio_receiving = 1'($urandom_range(0, 1));
        ev.rx_started      = 1'($urandom_range(0, 1));
        ev.tx_ok           = 1'($urandom_range(0, 1));
        ev.cur_phase       = $urandom;
        ev.wake_phase      = ($urandom_range(0, 7) == 0) ? ev.cur_phase : $urandom;
        return ev;
    endfunction

    function automatic dcmr_pkg::t_in_item frame_to(input logic [2:0] ft,
                                                    input logic [63:0] src,
                                                    input logic [63:0] dst);
        dcmr_pkg::t_in_item ev;
        ev            = rand_event(dcmr_pkg::OP_FRAME);
        ev.frame_type = ft;
        ev.parse_ok   = 1'b1;
        ev.frame_src  = src;
        ev.frame_dst  = dst;
        return ev;
    endfunction

    function automatic dcmr_pkg::t_in_item wakeup_request(input logic [63:0] src,
                                                          input logic busy);
        dcmr_pkg::t_in_item ev;
        ev                 = frame_to(dcmr_pkg::FT_REQUEST, src, own_now);
        ev.radio_receiving = busy;
        return ev;
    endfunction

    function automatic dcmr_pkg::t_in_item ack_result(input logic ok);
        dcmr_pkg::t_in_item ev;
        ev       = rand_event(dcmr_pkg::OP_ACK_RES);
        ev.tx_ok = ok;
        return ev;
    endfunction

    function automatic dcmr_pkg::t_in_item tick_event(input logic started);
        dcmr_pkg::t_in_item ev;
        ev            = rand_event(dcmr_pkg::OP_TICK);
        ev.rx_started = started;
        return ev;
    endfunction

    // Called on a falling edge; returns on the falling edge after the transaction was taken.
    task automatic send_event(input dcmr_pkg::t_in_item ev);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do begin
            @(negedge clk);
        end while (!in_accepted);
        sent_items++;
    endtask

    // Stops offering and waits until every expected result has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    // Only called while the block is idle.
    task automatic write_settings(input logic [63:0] own, input logic [19:0] ticks,
                                  input logic [31:0] wake);
        cfg_we    <= 1'b1;
        cfg_addr  <= dcmr_pkg::CFG_OWN_ADDR;
        cfg_wdata <= own;
        @(negedge clk);
        cfg_addr  <= dcmr_pkg::CFG_DATA_WAIT_TICKS;
        cfg_wdata <= {44'd0, ticks};
        @(negedge clk);
        cfg_addr  <= dcmr_pkg::CFG_WAKE_INTERVAL;
        cfg_wdata <= {32'd0, wake};
        @(negedge clk);
        cfg_we    <= 1'b0;
        own_now    = own;
    endtask

    // Mostly full handshakes with random content, some short failing listens and noise.
    task automatic run_mix(input int n);
        int                 stop_at;
        int                 steps;
        logic [63:0]        peer;
        dcmr_pkg::t_in_item ev;
        stop_at = sent_items + n;
        while (sent_items < stop_at) begin
            case ($urandom_range(0, 9))
                0: begin
                    ev = rand_event(3'($urandom_range(0, 7)));
                    if ($urandom_range(0, 1)) begin
                        ev.frame_dst = own_now;
                    end
                    send_event(ev);
                end
                1: begin
                    send_event(rand_event(dcmr_pkg::OP_START));
                    ev = frame_to(dcmr_pkg::FT_BROADCAST, rand_addr(), rand_addr());
                    ev.parse_ok = ($urandom_range(0, 3) != 0);
                    send_event(ev);
                end
                2, 3: begin
                    send_event(rand_event(dcmr_pkg::OP_START));
                    repeat ($urandom_range(0, 3)) begin
                        send_event(frame_to(3'($urandom_range(0, 7)), rand_addr(),
                                            rand_addr()));
                    end
                    send_event(rand_event(dcmr_pkg::OP_BATCH_END));
                end
                default: begin
                    send_event(rand_event(dcmr_pkg::OP_START));
                    peer = rand_addr();
                    send_event(wakeup_request(peer, $urandom_range(0, 4) == 0));
                    send_event(ack_result($urandom_range(0, 4) != 0));
                    steps = $urandom_range(1, 10);
                    repeat (steps) begin
                        case ($urandom_range(0, 9))
                            0: send_event(frame_to(dcmr_pkg::FT_BROADCAST, rand_addr(),
                                                   rand_addr()));
                            1: begin
                                // Either a stranger or a frame addressed elsewhere.
                                ev = frame_to(3'($urandom_range(0, 7)), peer, own_now);
                                if ($urandom_range(0, 1)) begin
                                    ev.frame_src = rand_addr();
                                end else begin
                                    ev.frame_dst = rand_addr();
                                end
                                send_event(ev);
                            end
                            2: begin
                                ev = frame_to(dcmr_pkg::FT_ACK, peer, own_now);
                                if ($urandom_range(0, 1)) begin
                                    ev.frame_type = 3'($urandom_range(dcmr_pkg::FT_OTHER,
                                                                      FT_UNDEF_HI));
                                end
                                send_event(ev);
                            end
                            3, 4, 5: send_event(tick_event($urandom_range(0, 3) == 0));
                            6: begin
                                send_event(wakeup_request(peer, $urandom_range(0, 4) == 0));
                                send_event(ack_result($urandom_range(0, 4) != 0));
                            end
                            7: begin
                                ev = frame_to(dcmr_pkg::FT_DATA, peer, own_now);
                                if ($urandom_range(0, 1)) begin
                                    ev.frame_type = dcmr_pkg::FT_DATA_PENDING;
                                end
                                send_event(ev);
                            end
                            8: begin
                                ev = frame_to(dcmr_pkg::FT_DATA, peer, own_now);
                                ev.parse_ok = 1'b0;
                                send_event(ev);
                            end
                            default: send_event(rand_event(3'($urandom_range(0, 7))));
                        endcase
                    end
                end
            endcase
        end
    endtask

    initial begin
        dcmr_pkg::t_in_item ev;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= dcmr_pkg::CFG_OWN_ADDR;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: a short timer so both the countdown and the expiry show up.
        write_settings(OWN_DIRECTED, 20'd2, 32'd123457);

        // Waiting for a request: parse error, request for someone else, no request at all.
        send_event(rand_event(dcmr_pkg::OP_START));
        ev = frame_to(dcmr_pkg::FT_BROADCAST, rand_addr(), rand_addr());
        ev.parse_ok = 1'b0;
        send_event(ev);
        send_event(frame_to(dcmr_pkg::FT_REQUEST, rand_addr(), ~OWN_DIRECTED));
        send_event(rand_event(dcmr_pkg::OP_BATCH_END));

        // A request while the radio is busy fails the listen.
        send_event(rand_event(dcmr_pkg::OP_START));
        send_event(wakeup_request(PEER_DIRECTED, 1'b1));

        // Full handshake with extreme phases, then the data wait with its side cases.
        send_event(rand_event(dcmr_pkg::OP_START));
        ev = wakeup_request(PEER_DIRECTED, 1'b0);
        ev.cur_phase  = '1;
        ev.wake_phase = '0;
        send_event(ev);
        send_event(ack_result(1'b1));
        send_event(frame_to(dcmr_pkg::FT_BROADCAST, '0, '1));
        send_event(frame_to(dcmr_pkg::FT_DATA, '0, OWN_DIRECTED));
        send_event(tick_event(1'b0));
        send_event(tick_event(1'b1));
        send_event(frame_to(dcmr_pkg::FT_OTHER, PEER_DIRECTED, OWN_DIRECTED));

        // A repeated request with equal phases takes the wrap path; its ack then fails.
        ev = wakeup_request(PEER_DIRECTED, 1'b0);
        ev.cur_phase  = 32'd0;
        ev.wake_phase = 32'd0;
        send_event(ev);
        send_event(ack_result(1'b0));

        // Data timeout with no reception in progress.
        send_event(rand_event(dcmr_pkg::OP_START));
        send_event(wakeup_request(PEER_DIRECTED, 1'b0));
        send_event(ack_result(1'b1));
        send_event(tick_event(1'b0));
        send_event(tick_event(1'b0));

        // Broadcast ends a listen with success; a frame after that is only dropped.
        send_event(rand_event(dcmr_pkg::OP_START));
        send_event(frame_to(dcmr_pkg::FT_BROADCAST, rand_addr(), rand_addr()));
        send_event(frame_to(dcmr_pkg::FT_DATA, PEER_DIRECTED, OWN_DIRECTED));

        // Data pending from the peer completes the handshake, then undefined ops and stop.
        send_event(rand_event(dcmr_pkg::OP_START));
        send_event(wakeup_request(PEER_DIRECTED, 1'b0));
        send_event(ack_result(1'b1));
        send_event(frame_to(dcmr_pkg::FT_DATA_PENDING, PEER_DIRECTED, OWN_DIRECTED));
        send_event(rand_event(OP_UNDEF_LO));
        send_event(rand_event(OP_UNDEF_HI));
        send_event(rand_event(dcmr_pkg::OP_STOP));
        drain();

        // Slow receiver, smallest settings: the timer expires on the first tick unless rx_started.
        write_settings('0, 20'd1, 32'd1);
        hold_requests++;
        run_mix(420);
        drain();

        // Slow sender, all-ones address and the widest wake interval.
        send_idle_pct = 87;
        recv_idle_pct = 21;
        write_settings('1, 20'd5, 32'hFFFF_FFFF);
        run_mix(420);
        drain();

        // No idling, longest data wait. A burst of failed listens drives the failure
        // counter up while the receiver is held off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_settings({$urandom, $urandom}, 20'hF_FFFF, $urandom | 32'd1);
        hold_requests++;
        repeat (140) begin
            send_event(rand_event(dcmr_pkg::OP_START));
            send_event(rand_event(dcmr_pkg::OP_BATCH_END));
        end
        run_mix(160);
        drain();

        // Room for any stray result to show up before the verdict.
        repeat (4) @(negedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/dcmr_pkg.sv
rtl/dcmr_fsm.sv
rtl/duty_cycled_mac_receive_fsm.sv
rtl/dcmr_checker.sv
bench/mac_rx_checker.sv
bench/testbench.sv
